### design/mcst_pkg.sv
package mcst_pkg;

  // Fixed widths of the request and result fields.
  localparam int REQ_W  = 3;
  localparam int ID_W   = 3;
  localparam int TICK_W = 32;

  // At most this many expiry words are reported for one tick.
  localparam int MAX_RESULTS = 8;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  // Request codes; the codes above REQ_DELETE are unknown requests.
  typedef enum logic [REQ_W-1:0] {
    REQ_TICK   = 3'd0,
    REQ_CREATE = 3'd1,
    REQ_START  = 3'd2,
    REQ_STOP   = 3'd3,
    REQ_DELETE = 3'd4
  } req_e;

  // Timer state codes held in each cell.
  localparam logic [1:0] TS_UNUSED  = 2'd0;
  localparam logic [1:0] TS_STOPPED = 2'd1;
  localparam logic [1:0] TS_RUNNING = 2'd2;

  // Result word codes.
  localparam logic KIND_STATUS    = 1'b0;
  localparam logic KIND_EVENT     = 1'b1;
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  // Command sent to one cell.
  typedef struct packed {
    logic              sel;
    logic [REQ_W-1:0]  op;
    logic [TICK_W-1:0] period;
    logic              periodic;
  } cell_cmd_t;

  // Scan control broadcast to all cells.
  typedef struct packed {
    logic              shift;
    logic [TICK_W-1:0] now;
  } scan_t;

  // What each cell reports back.
  typedef struct packed {
    logic used;
    logic running;
    logic hit;
  } cell_stat_t;

endpackage

### design/mcst_if.sv
// Request channel: one word per tick or command.
interface mcst_req_if;
  logic                             valid;
  logic                             ready;
  logic [mcst_pkg::REQ_W-1:0]       req_type;
  logic [mcst_pkg::ID_W-1:0]        timer_id;
  logic [mcst_pkg::TICK_W-1:0]      period;
  logic                             periodic;

  modport source (output valid, req_type, timer_id, period, periodic, input ready);
  modport sink   (input valid, req_type, timer_id, period, periodic, output ready);
endinterface

// Result channel: command status and expiry event words.
interface mcst_res_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [mcst_pkg::ID_W-1:0]   timer_id_res;
  logic                        status;
  logic                        last;

  modport source (output valid, kind, timer_id_res, status, last, input ready);
  modport sink   (input valid, kind, timer_id_res, status, last, output ready);
endinterface

### design/mcst_cell.sv
module mcst_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mcst_pkg::cell_cmd_t    cmd_i,
  input  mcst_pkg::scan_t        scan_i,
  input  logic                   tok_i,
  output logic                   tok_o,
  output mcst_pkg::cell_stat_t   stat_o
);
  import mcst_pkg::*;

  logic [1:0]        state_q, state_d;
  logic              periodic_q, periodic_d;
  logic              tok_q;
  logic [TICK_W-1:0] expire_q, expire_d;
  logic [TICK_W-1:0] reload_q, reload_d;
  logic [TICK_W-1:0] next_expire;
  logic              hit;

  // One adder serves both start and periodic reload.
  assign next_expire = scan_i.now + reload_q;
  assign hit = tok_q && (state_q == TS_RUNNING) && (expire_q == scan_i.now);

  assign tok_o          = tok_q;
  assign stat_o.used    = (state_q != TS_UNUSED);
  assign stat_o.running = (state_q == TS_RUNNING);
  assign stat_o.hit     = hit;

  // Commands and the scan never fall in the same cycle.
  always_comb begin
    state_d    = state_q;
    periodic_d = periodic_q;
    expire_d   = expire_q;
    reload_d   = reload_q;
    if (cmd_i.sel) begin
      unique case (cmd_i.op)
        REQ_CREATE: begin
          reload_d   = cmd_i.period;
          periodic_d = cmd_i.periodic;
          state_d    = TS_STOPPED;
        end
        REQ_START: begin
          if (state_q != TS_UNUSED) begin
            expire_d = next_expire;
            state_d  = TS_RUNNING;
          end
        end
        REQ_STOP: begin
          if (state_q == TS_RUNNING) begin
            state_d = TS_STOPPED;
          end
        end
        REQ_DELETE: begin
          state_d    = TS_UNUSED;
          periodic_d = 1'b0;
        end
        default: ;
      endcase
    end else if (scan_i.shift && hit) begin
      if (periodic_q) begin
        expire_d = next_expire;
      end else begin
        state_d = TS_STOPPED;
      end
    end
  end

  // Control state and the scan token.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= TS_UNUSED;
      periodic_q <= 1'b0;
      tok_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      periodic_q <= periodic_d;
      if (scan_i.shift) begin
        tok_q <= tok_i;
      end
    end
  end

  // Timer values are only read after a create has written them.
  always_ff @(posedge clk_i) begin
    expire_q <= expire_d;
    reload_q <= reload_d;
  end

endmodule

### design/multi_channel_soft_timer.sv
// Channel   Dir  Words carried
// req_i     in   tick, create, start, stop, delete requests
// res_o     out  command status and timer expiry events
//
// A command's status word appears in the next cycle after the command is taken.
// A tick sends a token down the chain of timer cells, one cell per cycle, and
// no new word is taken until the token has left the last cell and the flush ends.
// A stall on res_o freezes the token in place until the output register frees.
// Reset clears the tick count and marks every timer unused.
module multi_channel_soft_timer #(
  parameter int NUM_TIMERS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mcst_req_if.sink    req_i,
  mcst_res_if.source  res_o
);
  import mcst_pkg::*;

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int SEL_W = (IDX_W > ID_W) ? IDX_W : ID_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [TICK_W-1:0] tick_q;
  logic [IDX_W-1:0]  idx_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              pend_q;
  logic [ID_W-1:0]   pend_id_q;

  logic              out_valid_q, out_valid_d;
  logic              out_kind_q, out_kind_d;
  logic [ID_W-1:0]   out_id_q, out_id_d;
  logic              out_status_q, out_status_d;
  logic              out_last_q, out_last_d;

  logic              out_free, in_fire, tick_start, cmd_fire, adv, report, scan_end;
  logic              cmd_status;
  scan_t             scan;
  cell_cmd_t         cmd [NUM_TIMERS];
  cell_stat_t        stat [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] tok_out, addr_vec, used_vec, run_vec, hit_vec;

  // Handshake.
  assign out_free    = !out_valid_q || res_o.ready;
  assign req_i.ready = (state_q == S_IDLE) && out_free;
  assign in_fire     = req_i.valid && req_i.ready;
  assign tick_start  = in_fire && (req_i.req_type == REQ_TICK);
  assign cmd_fire    = in_fire && (req_i.req_type != REQ_TICK);
  assign adv         = (state_q == S_SCAN) && out_free;
  assign report      = (|hit_vec) && (cnt_q < CNT_W'(MAX_RESULTS));
  assign scan_end    = tok_out[NUM_TIMERS-1];

  assign scan.shift = tick_start || adv;
  assign scan.now   = tick_q;

  // Chain of timer cells; the token enters at cell zero on a tick.
  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    assign addr_vec[i]     = (SEL_W'(req_i.timer_id) == SEL_W'(i));
    assign cmd[i].sel      = cmd_fire && addr_vec[i];
    assign cmd[i].op       = req_i.req_type;
    assign cmd[i].period   = req_i.period;
    assign cmd[i].periodic = req_i.periodic;
    assign used_vec[i]     = stat[i].used;
    assign run_vec[i]      = stat[i].running;
    assign hit_vec[i]      = stat[i].hit;

    mcst_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd[i]),
      .scan_i (scan),
      .tok_i  ((i == 0) ? tick_start : tok_out[(i == 0) ? 0 : i - 1]),
      .tok_o  (tok_out[i]),
      .stat_o (stat[i])
    );
  end

  // Command status; an out-of-range slot matches no cell.
  always_comb begin
    unique case (req_i.req_type) inside
      REQ_CREATE, REQ_DELETE: begin
        cmd_status = (int'(req_i.timer_id) < NUM_TIMERS) ? STATUS_OK : STATUS_REFUSED;
      end
      REQ_START: cmd_status = (|(addr_vec & used_vec)) ? STATUS_OK : STATUS_REFUSED;
      REQ_STOP:  cmd_status = (|(addr_vec & run_vec)) ? STATUS_OK : STATUS_REFUSED;
      default:   cmd_status = STATUS_REFUSED;
    endcase
  end

  // Output register. One expiry is held back so that the final one can carry last.
  always_comb begin
    out_valid_d  = out_valid_q && !res_o.ready;
    out_kind_d   = out_kind_q;
    out_id_d     = out_id_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    if (cmd_fire) begin
      out_valid_d  = 1'b1;
      out_kind_d   = KIND_STATUS;
      out_id_d     = req_i.timer_id;
      out_status_d = cmd_status;
      out_last_d   = 1'b1;
    end else if ((adv && report && pend_q) ||
                 ((state_q == S_FLUSH) && out_free && pend_q)) begin
      out_valid_d  = 1'b1;
      out_kind_d   = KIND_EVENT;
      out_id_d     = pend_id_q;
      out_status_d = STATUS_OK;
      out_last_d   = (state_q == S_FLUSH);
    end
  end

  // Scan sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (tick_start) state_d = S_SCAN;
      S_SCAN:  if (adv && scan_end) state_d = S_FLUSH;
      S_FLUSH: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tick_q      <= '0;
      idx_q       <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (tick_start) begin
        tick_q <= tick_q + TICK_W'(1);
        idx_q  <= '0;
        cnt_q  <= '0;
        pend_q <= 1'b0;
      end else if (adv) begin
        idx_q <= idx_q + IDX_W'(1);
        if (report) begin
          pend_q <= 1'b1;
          cnt_q  <= cnt_q + CNT_W'(1);
        end
      end else if ((state_q == S_FLUSH) && out_free) begin
        pend_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    out_kind_q   <= out_kind_d;
    out_id_q     <= out_id_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
    if (adv && report) begin
      pend_id_q <= ID_W'(idx_q);
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.kind         = out_kind_q;
  assign res_o.timer_id_res = out_id_q;
  assign res_o.status       = out_status_q;
  assign res_o.last         = out_last_q;

endmodule

### design/mcst_checker.sv
module mcst_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       req_valid_i,
  input logic                       req_ready_i,
  input logic [mcst_pkg::REQ_W-1:0] req_type_i,
  input logic                       res_valid_i,
  input logic                       res_ready_i,
  input logic                       res_kind_i,
  input logic [mcst_pkg::ID_W-1:0]  res_id_i,
  input logic                       res_status_i,
  input logic                       res_last_i
);
  import mcst_pkg::*;

  // A stalled result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_kind_i) &&
      $stable(res_id_i) && $stable(res_status_i) && $stable(res_last_i))
    else $error("result word changed while stalled");

  // Every accepted command answers with one final status word in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && (req_type_i != REQ_TICK) |=>
      res_valid_i && (res_kind_i == KIND_STATUS) && res_last_i)
    else $error("command status word missing");

  // A status word is always the only word of its request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_kind_i == KIND_STATUS) |-> res_last_i)
    else $error("status word without last");

  // Expiry events are never refused.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_kind_i == KIND_EVENT) |-> (res_status_i == STATUS_OK))
    else $error("expiry event with refused status");

  // No new request is taken while a tick still has events to deliver.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_ready_i && (res_kind_i == KIND_EVENT) && !res_last_i |->
      !req_ready_i)
    else $error("request taken in the middle of a tick");

endmodule

bind multi_channel_soft_timer mcst_checker u_mcst_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .req_type_i   (req_i.req_type),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_kind_i   (res_o.kind),
  .res_id_i     (res_o.timer_id_res),
  .res_status_i (res_o.status),
  .res_last_i   (res_o.last)
);
